/* design/text_search_line_locator_macros.svh */
// Assertion macros shared by the text search line locator modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEXT_SEARCH_LINE_LOCATOR_MACROS_SVH
`define TEXT_SEARCH_LINE_LOCATOR_MACROS_SVH

// Same-cycle implication.
`define TSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text_search_line_locator: assertion failed");

// Next-cycle implication.
`define TSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_search_line_locator: assertion failed");

`endif

/* design/tsl_pkg.sv */
// Shared types and constants for the text search line locator.
// No dependencies.
package tsl_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_CASE_EXACT   = 3'd3,
    REG_WHOLE_WORD   = 3'd4
  } tsl_reg_t;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [4:0]  pattern_length;
    logic        case_exact;
    logic        whole_word_only;
  } tsl_cfg_t;

  typedef struct packed {
    logic [31:0] match_offset;
    logic [31:0] line_number;
    logic [31:0] line_column;
    logic        last_of_run;
  } tsl_result_t;

  typedef struct packed {
    logic [1:0]  count;
    tsl_result_t first;
    tsl_result_t second;
  } tsl_batch_t;

endpackage

/* design/text_search_line_locator.sv */
// Streaming substring locator: reports offset, line and column of every
// pattern occurrence (only whole words, if so configured) in a character
// stream. Uses tsl_pkg, tsl_cfg_regs, tsl_match_core and tsl_out_buf.
//
// One character is taken per cycle while in_ready is high. A character is held
// in an input register, compared against the pattern window there and its
// results are written to a two-entry output buffer once the buffer has room,
// which frees the register. Results leave one per cycle while out_ready is
// high; a character that yields two results (a deferred whole-word match plus
// one reported at once) offers the deferred one first. The input stays open
// while the input register is empty, or the output buffer is empty or holds
// one result that is being drained in the same cycle, so the sustained rate is
// one character per cycle whenever the result side keeps up.
module text_search_line_locator
  import tsl_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_char,
  input  logic                   in_end_of_text,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            out_match_offset,
  output logic [31:0]            out_line_number,
  output logic [31:0]            out_line_column,
  output logic                   out_last_of_run
);

  tsl_cfg_t    cfg;
  tsl_batch_t  batch;
  tsl_result_t head;
  logic        push;
  logic        space_ok;

  tsl_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsl_match_core #(
    .PATTERN_MAX  (PATTERN_MAX),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_match_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_char   (in_text_char),
    .in_end_of_text (in_end_of_text),
    .space_ok       (space_ok),
    .push           (push),
    .batch          (batch)
  );

  tsl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .batch     (batch),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_match_offset = head.match_offset;
  assign out_line_number  = head.line_number;
  assign out_line_column  = head.line_column;
  assign out_last_of_run  = head.last_of_run;

endmodule

/* design/tsl_cfg_regs.sv */
// Configuration register file for the text search line locator.
// Depends on tsl_pkg.
module tsl_cfg_regs
  import tsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output tsl_cfg_t               cfg
);

  tsl_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low     <= '0;
      cfg_r.pattern_high    <= '0;
      cfg_r.pattern_length  <= 5'd1;
      cfg_r.case_exact      <= 1'b0;
      cfg_r.whole_word_only <= 1'b0;
    end else if (cfg_write) begin
      case (tsl_reg_t'(cfg_index))
        REG_PATTERN_LOW:  cfg_r.pattern_low     <= cfg_data;
        REG_PATTERN_HIGH: cfg_r.pattern_high    <= cfg_data;
        REG_PATTERN_LEN:  cfg_r.pattern_length  <= cfg_data[4:0];
        REG_CASE_EXACT:   cfg_r.case_exact      <= cfg_data[0];
        REG_WHOLE_WORD:   cfg_r.whole_word_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* design/tsl_match_core.sv */
// Input register, character window, line/column tracking and pattern compare.
// Depends on tsl_pkg and text_search_line_locator_macros.svh.
`include "text_search_line_locator_macros.svh"
module tsl_match_core
  import tsl_pkg::*;
#(
  parameter int PATTERN_MAX  = 16,
  parameter int COUNTER_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  tsl_cfg_t   cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_char,
  input  logic       in_end_of_text,
  input  logic       space_ok,
  output logic       push,
  output tsl_batch_t batch
);

  localparam int WIN_DEPTH = PATTERN_MAX + 2;
  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int PIDX_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic exact);
    if (!exact && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'h20;
    end
    return c;
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) ||
           (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  logic                    s1_valid_r;
  logic [7:0]              s1_char_r;
  logic                    s1_eot_r;
  logic                    fire;

  logic [7:0]              win_char_r   [WIN_DEPTH];
  logic [7:0]              win_char_nxt [WIN_DEPTH];
  logic [COUNTER_BITS-1:0] win_line_r   [WIN_DEPTH];
  logic [COUNTER_BITS-1:0] win_line_nxt [WIN_DEPTH];
  logic [COUNTER_BITS-1:0] win_col_r    [WIN_DEPTH];
  logic [COUNTER_BITS-1:0] win_col_nxt  [WIN_DEPTH];
  logic [WIN_DEPTH-1:0]    win_valid_r, win_valid_sh, win_valid_nxt;

  logic [COUNTER_BITS-1:0] pos_r, line_r, line_nxt, col_r, col_nxt;
  logic                    acr_r, acr_nxt, defer_r, defer_nxt;

  logic                    lf_join;
  logic [COUNTER_BITS-1:0] arr_line, arr_col;
  logic [LEN_W-1:0]        eff_len;
  logic [127:0]            pat_all;
  logic [PATTERN_MAX-1:0][7:0] pat_f;
  logic [PATTERN_MAX-1:0]  ok_vec;

  logic [7:0]              char_at_len;
  logic                    valid_at_len;
  logic [COUNTER_BITS-1:0] line_at_len, col_at_len, line_at_lm1, col_at_lm1;
  logic [COUNTER_BITS-1:0] off_def, off_cand;
  logic                    cand, cand_emit, def_hit;
  tsl_result_t             res_def, res_cand;

  assign fire     = s1_valid_r && space_ok;
  assign in_ready = !s1_valid_r || space_ok;
  assign push     = fire;
  assign pat_all  = {cfg.pattern_high, cfg.pattern_low};

  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      eff_len = LEN_W'(1);
    end else if (int'(cfg.pattern_length) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(cfg.pattern_length);
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < 16) begin
        pat_f[i] = fold(pat_all[8*(i % 16) +: 8], cfg.case_exact);
      end else begin
        pat_f[i] = 8'h00;
      end
    end
  end

  always_comb begin
    lf_join = (s1_char_r == CH_LF) && acr_r && win_valid_r[0];
    if (lf_join) begin
      arr_line = win_line_r[0];
      arr_col  = sat_inc(win_col_r[0]);
      line_nxt = line_r;
      col_nxt  = col_r;
      acr_nxt  = 1'b0;
    end else begin
      arr_line = line_r;
      arr_col  = col_r;
      if (s1_char_r == CH_CR || s1_char_r == CH_LF) begin
        line_nxt = sat_inc(line_r);
        col_nxt  = '0;
      end else begin
        line_nxt = line_r;
        col_nxt  = sat_inc(col_r);
      end
      acr_nxt = (s1_char_r == CH_CR);
    end
  end

  always_comb begin
    win_char_nxt[0] = s1_char_r;
    win_line_nxt[0] = arr_line;
    win_col_nxt[0]  = arr_col;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_char_nxt[k] = win_char_r[k-1];
      win_line_nxt[k] = win_line_r[k-1];
      win_col_nxt[k]  = win_col_r[k-1];
    end
    win_valid_sh  = {win_valid_r[WIN_DEPTH-2:0], 1'b1};
    win_valid_nxt = s1_eot_r ? '0 : win_valid_sh;
  end

  always_comb begin
    char_at_len  = '0;
    valid_at_len = 1'b0;
    line_at_len  = '0;
    col_at_len   = '0;
    line_at_lm1  = '0;
    col_at_lm1   = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (k == int'(eff_len)) begin
        char_at_len  = win_char_nxt[k];
        valid_at_len = win_valid_sh[k];
        line_at_len  = win_line_nxt[k];
        col_at_len   = win_col_nxt[k];
      end
      if (k == int'(eff_len) - 1) begin
        line_at_lm1 = win_line_nxt[k];
        col_at_lm1  = win_col_nxt[k];
      end
    end
  end

  always_comb begin
    logic [PIDX_W-1:0] pi;
    pi = '0;
    for (int idx = 0; idx < PATTERN_MAX; idx++) begin
      if (idx < int'(eff_len)) begin
        pi = PIDX_W'(int'(eff_len) - 1 - idx);
        ok_vec[idx] = win_valid_sh[idx] &&
                      (fold(win_char_nxt[idx], cfg.case_exact) == pat_f[pi]);
      end else begin
        ok_vec[idx] = 1'b1;
      end
    end
  end

  always_comb begin
    cand = (&ok_vec) &&
           (!cfg.whole_word_only || !valid_at_len || is_boundary(char_at_len));
    cand_emit = cand && (!cfg.whole_word_only || s1_eot_r);
    defer_nxt = cand && cfg.whole_word_only && !s1_eot_r;
    def_hit   = defer_r && is_boundary(s1_char_r) && valid_at_len;

    off_def  = (pos_r == CNT_MAX) ? CNT_MAX : pos_r - COUNTER_BITS'(eff_len);
    off_cand = (pos_r == CNT_MAX) ? CNT_MAX : pos_r - COUNTER_BITS'(eff_len - 1'b1);

    res_def.match_offset  = 32'(off_def);
    res_def.line_number   = 32'(line_at_len);
    res_def.line_column   = 32'(col_at_len);
    res_def.last_of_run   = !cand_emit;
    res_cand.match_offset = 32'(off_cand);
    res_cand.line_number  = 32'(line_at_lm1);
    res_cand.line_column  = 32'(col_at_lm1);
    res_cand.last_of_run  = 1'b1;

    batch.count  = {def_hit && cand_emit, def_hit ^ cand_emit};
    batch.first  = def_hit ? res_def : res_cand;
    batch.second = res_cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_valid_r <= '0;
      pos_r       <= '0;
      line_r      <= COUNTER_BITS'(1);
      col_r       <= '0;
      acr_r       <= 1'b0;
      defer_r     <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        win_valid_r <= win_valid_nxt;
        pos_r       <= s1_eot_r ? '0 : sat_inc(pos_r);
        line_r      <= s1_eot_r ? COUNTER_BITS'(1) : line_nxt;
        col_r       <= s1_eot_r ? '0 : col_nxt;
        acr_r       <= acr_nxt && !s1_eot_r;
        defer_r     <= defer_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_text_char;
      s1_eot_r  <= in_end_of_text;
    end
    if (fire) begin
      win_char_r <= win_char_nxt;
      win_line_r <= win_line_nxt;
      win_col_r  <= win_col_nxt;
    end
  end

  `TSL_ASSERT_NOW(a_defer_needs_word_mode, $rose(defer_r), $past(cfg.whole_word_only))
  `TSL_ASSERT_NOW(a_pair_order, push && batch.count == 2'd2, !batch.first.last_of_run && batch.second.last_of_run)
  `TSL_ASSERT_NEXT(a_hold_when_stalled, s1_valid_r && !space_ok, s1_valid_r && $stable(s1_char_r))

endmodule

/* design/tsl_out_buf.sv */
// Two-entry result buffer feeding the output channel.
// Depends on tsl_pkg and text_search_line_locator_macros.svh.
`include "text_search_line_locator_macros.svh"
module tsl_out_buf
  import tsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  tsl_batch_t  batch,
  output logic        space_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output tsl_result_t head
);

  logic [1:0]  cnt_r, cnt_nxt;
  tsl_result_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic        pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign space_ok  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign head      = slot0_r;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (push) begin
      cnt_nxt   = batch.count;
      slot0_nxt = batch.first;
      slot1_nxt = batch.second;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  `TSL_ASSERT_NOW(a_push_has_room, push, space_ok)
  `TSL_ASSERT_NOW(a_tail_is_last, cnt_r == 2'd2, slot1_r.last_of_run)
  `TSL_ASSERT_NEXT(a_fill_count, push, cnt_r == $past(batch.count))

endmodule

/* sim/tsl_match_check.sv */
// Watches the text search line locator channels, predicts every match report
// and compares it with what the block returns. Uses tsl_pkg.
module tsl_match_check
  import tsl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             in_text_char,
  input  logic                   in_end_of_text,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [31:0]            out_match_offset,
  input  logic [31:0]            out_line_number,
  input  logic [31:0]            out_line_column,
  input  logic                   out_last_of_run,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_BYTES = 16;
  localparam int WIN = PATTERN_BYTES + 2;
  localparam logic [31:0] CNT_TOP = '1;

  tsl_cfg_t    regs;
  logic [7:0]  win_char [WIN];
  logic        win_used [WIN];
  logic [31:0] win_line [WIN];
  logic [31:0] win_col [WIN];
  logic [31:0] char_pos;
  logic [31:0] line_now;
  logic [31:0] col_now;
  logic        cr_seen;
  logic        word_held;
  tsl_result_t expected_hits [$];
  int          errs;

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == CNT_TOP) ? v : v + 32'd1;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    if (!regs.case_exact && c >= 8'h41 && c <= 8'h5A) return c + 8'h20;
    return c;
  endfunction

  function automatic bit is_separator(logic [7:0] c);
    if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) return 1'b1;
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic int pat_len();
    if (regs.pattern_length == 5'd0) return 1;
    if (regs.pattern_length > PATTERN_BYTES) return PATTERN_BYTES;
    return int'(regs.pattern_length);
  endfunction

  function automatic logic [7:0] pat_byte(int i);
    if (i < 8) return regs.pattern_low[8*i +: 8];
    if (i < 16) return regs.pattern_high[8*(i-8) +: 8];
    return 8'h00;
  endfunction

  function automatic bit ends_here(int len, bit need_left);
    int idx;
    for (int i = 0; i < len; i++) begin
      idx = len - 1 - i;
      if (!win_used[idx]) return 1'b0;
      if (fold_case(win_char[idx]) != fold_case(pat_byte(i))) return 1'b0;
    end
    if (need_left && win_used[len] && !is_separator(win_char[len])) return 1'b0;
    return 1'b1;
  endfunction

  function automatic tsl_result_t make_hit(logic [31:0] offset, int start);
    tsl_result_t r;
    r.match_offset = offset;
    r.line_number  = win_line[start];
    r.line_column  = win_col[start];
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  task automatic clear_text();
    for (int k = 0; k < WIN; k++) begin
      win_char[k] = 8'h00;
      win_used[k] = 1'b0;
      win_line[k] = 32'd0;
      win_col[k]  = 32'd0;
    end
    char_pos  = 32'd0;
    line_now  = 32'd1;
    col_now   = 32'd0;
    cr_seen   = 1'b0;
    word_held = 1'b0;
  endtask

  task automatic predict_char(logic [7:0] c, logic eot);
    int          len;
    logic [31:0] pos;
    logic [31:0] ln;
    logic [31:0] col;
    bit          ww;
    tsl_result_t found [2];
    int          n;
    len = pat_len();
    pos = char_pos;
    ww  = regs.whole_word_only;
    n   = 0;
    if (c == CH_LF && cr_seen && win_used[0]) begin
      ln = win_line[0];
      col = bump(win_col[0]);
      cr_seen = 1'b0;
    end else begin
      ln = line_now;
      col = col_now;
      if (c == CH_CR || c == CH_LF) begin
        line_now = bump(line_now);
        col_now = 32'd0;
      end else begin
        col_now = bump(col_now);
      end
      cr_seen = (c == CH_CR);
    end
    for (int k = WIN - 1; k > 0; k--) begin
      win_char[k] = win_char[k-1];
      win_used[k] = win_used[k-1];
      win_line[k] = win_line[k-1];
      win_col[k]  = win_col[k-1];
    end
    win_char[0] = c;
    win_used[0] = 1'b1;
    win_line[0] = ln;
    win_col[0]  = col;
    char_pos = bump(char_pos);
    if (word_held && is_separator(c) && win_used[len]) begin
      found[n] = make_hit((pos == CNT_TOP) ? CNT_TOP : pos - len, len);
      n++;
    end
    word_held = 1'b0;
    if (ends_here(len, ww)) begin
      if (!ww || eot) begin
        found[n] = make_hit((pos == CNT_TOP) ? CNT_TOP : pos - (len - 1), len - 1);
        n++;
      end else begin
        word_held = 1'b1;
      end
    end
    for (int i = 0; i < n; i++) begin
      found[i].last_of_run = (i == n - 1);
      expected_hits = {expected_hits, found[i]};
    end
    if (eot) clear_text();
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  task automatic compare_hit();
    tsl_result_t want;
    if (expected_hits.size() == 0) begin
      $display("%0t unexpected result: expected none, got offset %0d line %0d column %0d",
               $time, out_match_offset, out_line_number, out_line_column);
      errs++;
    end else begin
      want = expected_hits.pop_front();
      check_field("match_offset", want.match_offset, out_match_offset);
      check_field("line_number", want.line_number, out_line_number);
      check_field("line_column", want.line_column, out_line_column);
      check_field("last_of_run", {31'd0, want.last_of_run}, {31'd0, out_last_of_run});
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.pattern_low     = 64'd0;
      regs.pattern_high    = 64'd0;
      regs.pattern_length  = 5'd1;
      regs.case_exact      = 1'b0;
      regs.whole_word_only = 1'b0;
      clear_text();
      expected_hits.delete();
      errs = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN_LOW:  regs.pattern_low = cfg_data;
          REG_PATTERN_HIGH: regs.pattern_high = cfg_data;
          REG_PATTERN_LEN:  regs.pattern_length = cfg_data[4:0];
          REG_CASE_EXACT:   regs.case_exact = cfg_data[0];
          REG_WHOLE_WORD:   regs.whole_word_only = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_char(in_text_char, in_end_of_text);
      if (out_valid && out_ready) compare_hit();
    end
    mismatches  <= errs;
    outstanding <= expected_hits.size();
  end

endmodule

/* sim/text_search_line_locator_tb.sv */
// Top of the text search line locator testbench: clock, reset, directed and
// random text streams, result back-pressure and the verdict.
// Depends on tsl_pkg, text_search_line_locator and tsl_match_check.
module text_search_line_locator_tb
  import tsl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 6;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int RANDOM_ITEMS    = 880;
  localparam int SQUEEZE_PHASE   = 3;

  localparam logic [4*8-1:0]  LETTER_SET = {8'h61, 8'h62, 8'h41, 8'h42};
  localparam logic [15*8-1:0] SEP_SET    = {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h2C, 8'h2E,
                                            8'h2D, 8'h21, 8'h2F, 8'h3A, 8'h40, 8'h5B,
                                            8'h60, 8'h7B, 8'h7E};
  localparam logic [14*8-1:0] WORD_SET   = {8'h61, 8'h62, 8'h41, 8'h5A, 8'h7A, 8'h30,
                                            8'h39, 8'h7F, 8'h80, 8'hC1, 8'h08, 8'h0E,
                                            8'h1F, 8'hFF};

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_PATTERN_LOW;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_text_char = 8'h00;
  logic                   in_end_of_text = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [31:0]            out_match_offset;
  logic [31:0]            out_line_number;
  logic [31:0]            out_line_column;
  logic                   out_last_of_run;
  int                     mismatches;
  int                     outstanding;
  int                     quiet_cycles = 0;
  bit                     squeeze_req = 1'b0;
  logic [7:0]             pat_bytes [16];
  int                     pat_used;
  bit                     fold_on;

  always #2 clk = ~clk;

  text_search_line_locator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_char(in_text_char), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_match_offset(out_match_offset), .out_line_number(out_line_number),
    .out_line_column(out_line_column), .out_last_of_run(out_last_of_run)
  );

  tsl_match_check u_hit_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_char(in_text_char), .in_end_of_text(in_end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_match_offset(out_match_offset), .out_line_number(out_line_number),
    .out_line_column(out_line_column), .out_last_of_run(out_last_of_run),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  function automatic int next_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] separator_byte();
    return SEP_SET[8*$urandom_range(0, 14) +: 8];
  endfunction

  function automatic logic [7:0] word_byte();
    return WORD_SET[8*$urandom_range(0, 13) +: 8];
  endfunction

  function automatic logic [7:0] pattern_choice();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return LETTER_SET[8*$urandom_range(0, 3) +: 8];
    if (r < 85) return separator_byte();
    if (r < 95) return word_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(logic [7:0] c, logic eot, int gap);
    in_valid <= 1'b1;
    in_text_char <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(tsl_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic configure(logic [63:0] low, logic [63:0] high, logic [4:0] len,
                           bit exact, bit ww);
    put_reg(REG_PATTERN_LOW, low);
    put_reg(REG_PATTERN_HIGH, high);
    put_reg(REG_PATTERN_LEN, {59'd0, len});
    put_reg(REG_CASE_EXACT, {63'd0, exact});
    put_reg(REG_WHOLE_WORD, {63'd0, ww});
    cfg_write <= 1'b0;
  endtask

  task automatic pick_setting();
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  len;
    bit          exact;
    int          r;
    for (int i = 0; i < 16; i++) pat_bytes[i] = pattern_choice();
    for (int i = 0; i < 8; i++) begin
      low[8*i +: 8]  = pat_bytes[i];
      high[8*i +: 8] = pat_bytes[i+8];
    end
    r = $urandom_range(0, 99);
    if (r < 70) len = 5'($urandom_range(1, 4));
    else if (r < 80) len = 5'($urandom_range(5, 16));
    else if (r < 85) len = 5'd16;
    else if (r < 90) len = 5'd0;
    else if (r < 95) len = 5'd17;
    else len = 5'd31;
    exact = 1'($urandom_range(0, 1));
    pat_used = (len == 5'd0) ? 1 : (len > 5'd16) ? 16 : int'(len);
    fold_on = !exact;
    configure(low, high, len, exact, 1'($urandom_range(0, 1)));
  endtask

  task automatic stream_text(int count, bit steady);
    logic [7:0] burst [$];
    logic [7:0] b;
    int         r;
    int         copy_len;
    logic       eot;
    for (int n = 0; n < count; n++) begin
      if (burst.size() == 0) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          if ($urandom_range(0, 1)) burst = {burst, separator_byte()};
          copy_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, pat_used) : pat_used;
          for (int j = 0; j < copy_len; j++) begin
            b = pat_bytes[j];
            if (fold_on && $urandom_range(0, 1) &&
                ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)))
              b = b ^ 8'h20;
            burst = {burst, b};
          end
        end else if (r < 60) begin
          burst = {burst, separator_byte()};
        end else if (r < 70) begin
          burst = {burst, ($urandom_range(0, 1) ? CH_CR : CH_LF)};
        end else if (r < 85) begin
          burst = {burst, word_byte()};
        end else begin
          burst = {burst, 8'($urandom_range(0, 255))};
        end
      end
      eot = ($urandom_range(0, 99) < 3) || (n == count - 1 && $urandom_range(0, 2) == 0);
      send(burst.pop_front(), eot, next_gap(steady));
    end
  endtask

  initial begin
    int random_left;
    int phase_no;
    int size;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset pattern is a single zero byte
    send(8'h00, 1'b0, next_gap(1'b0));
    send(8'hFF, 1'b0, next_gap(1'b0));
    send(8'h00, 1'b1, next_gap(1'b0));
    settle();

    configure(64'h6161, 64'h0, 5'd2, 1'b0, 1'b0);
    send(8'h61, 1'b0, next_gap(1'b0));
    send(8'h41, 1'b0, next_gap(1'b0));
    send(8'h61, 1'b0, next_gap(1'b0));
    send(CH_CR, 1'b0, next_gap(1'b0));
    send(CH_LF, 1'b0, next_gap(1'b0));
    send(8'h61, 1'b0, next_gap(1'b0));
    send(CH_CR, 1'b0, next_gap(1'b0));
    send(8'h61, 1'b0, next_gap(1'b0));
    send(CH_LF, 1'b0, next_gap(1'b0));
    send(8'h61, 1'b0, next_gap(1'b0));
    send(8'h41, 1'b1, next_gap(1'b0));
    settle();

    // held match and end-of-text match on the same character
    configure(64'h2C, 64'h0, 5'd1, 1'b1, 1'b1);
    send(8'h2C, 1'b0, next_gap(1'b0));
    send(8'h2C, 1'b1, next_gap(1'b0));
    settle();

    // leave a match held, then drop whole-word mode before the boundary
    configure(64'h6261, 64'h0, 5'd2, 1'b1, 1'b1);
    send(8'h61, 1'b0, next_gap(1'b0));
    send(8'h62, 1'b0, next_gap(1'b0));
    settle();
    configure(64'h6261, 64'h0, 5'd2, 1'b1, 1'b0);
    send(8'h20, 1'b1, next_gap(1'b0));
    settle();

    configure(64'h71, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b0, 1'b0);
    send(8'h51, 1'b0, next_gap(1'b0));
    send(8'h71, 1'b1, next_gap(1'b0));
    settle();

    random_left = RANDOM_ITEMS;
    phase_no = 0;
    while (random_left > 0) begin
      size = $urandom_range(20, 60);
      if (phase_no == SQUEEZE_PHASE) size = 60;
      if (size > random_left) size = random_left;
      if (phase_no == SQUEEZE_PHASE) begin
        configure(64'h61, 64'h0, 5'd1, 1'b1, 1'b0);
        squeeze_req = 1'b1;
        wait (!squeeze_req);
        for (int n = 0; n < size; n++)
          send(($urandom_range(0, 7) == 0) ? 8'h62 : 8'h61, 1'b0, 0);
      end else begin
        pick_setting();
        stream_text(size, $urandom_range(0, 3) == 0);
      end
      settle();
      random_left -= size;
      phase_no++;
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    int r;
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (r < 60) begin
          out_ready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end else if (r < 93) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_write || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

/* sim.f */
+incdir+design
design/tsl_pkg.sv
design/tsl_cfg_regs.sv
design/tsl_match_core.sv
design/tsl_out_buf.sv
design/text_search_line_locator.sv
sim/tsl_match_check.sv
sim/text_search_line_locator_tb.sv
